>>> hw/rtl/msrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msrc_pkg
// shared types, codes and the crc-16/modbus byte update for the reply checker
// ----------------------------------------------------------------------------
package msrc_pkg;

    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 16;
    localparam int POS_W     = 4;
    localparam int CFG_IDX_W = 8;

    localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;
    localparam logic [BYTE_W-1:0] FUNC_READ = 8'h03;
    localparam logic [POS_W-1:0]  COUNT_SPEED     = 4'd2;
    localparam logic [POS_W-1:0]  COUNT_DIRECTION = 4'd4;
    localparam logic [POS_W-1:0]  POS_ADDRESS  = 4'd0;
    localparam logic [POS_W-1:0]  POS_FUNCTION = 4'd1;
    localparam logic [POS_W-1:0]  POS_COUNT    = 4'd2;
    localparam logic [POS_W-1:0]  POS_DATA_HI  = 4'd3;
    localparam logic [POS_W-1:0]  POS_DATA_LO  = 4'd4;

    localparam logic [BYTE_W-1:0] SPEED_ADDR_RESET     = 8'd1;
    localparam logic [BYTE_W-1:0] DIRECTION_ADDR_RESET = 8'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_ADDR     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_ADDR = 8'd1;

    typedef enum logic [2:0] {
        FAIL_NONE     = 3'd0,
        FAIL_ADDRESS  = 3'd1,
        FAIL_FUNCTION = 3'd2,
        FAIL_COUNT    = 3'd3,
        FAIL_CRC      = 3'd4
    } fail_t;

    typedef struct packed {
        logic              valid;
        logic              accepted;
        logic              kind;
        logic [WORD_W-1:0] reading;
        fail_t             reason;
    } result_t;

    function automatic logic [WORD_W-1:0] crc_feed(input logic [WORD_W-1:0] crc_in,
                                                   input logic [BYTE_W-1:0] b);
        logic [WORD_W-1:0] c;
        c = crc_in ^ {{(WORD_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/modbus_sensor_reply_checker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_sensor_reply_checker_core
// checks modbus rtu replies from a wind speed or wind direction sensor
// ----------------------------------------------------------------------------
// result path: the frame's deciding byte, once accepted, passes the input register
//   and then the result register before its result appears on m_*
// throughput: one byte per cycle while m_tready is high; the crc byte update
//   is combinational between the input register and the parser's crc register
// reset: synchronous, active low; parser goes idle, addresses return to 1 and 2
// ----------------------------------------------------------------------------
module modbus_sensor_reply_checker_core (
    input  logic                              aclk,
    input  logic                              aresetn,

    // reply byte stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] rx_byte
    input  logic                              s_tuser,   // [0] frame_start

    // at most one result item per frame
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,   // [0] accepted, [16:1] reading,
                                                         // [19:17] fail_reason, rest zero
    output logic                              m_tuser,   // [0] sensor_kind

    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [msrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [msrc_pkg::BYTE_W-1:0]       cfg_data
);

    // configuration registers
    logic [msrc_pkg::BYTE_W-1:0] speed_addr_reg;
    logic [msrc_pkg::BYTE_W-1:0] direction_addr_reg;

    // input register
    logic                        in_valid_reg;
    logic [msrc_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        in_start_reg;

    // result register
    logic                        out_valid_reg, out_valid_next;
    msrc_pkg::result_t           out_reg;

    msrc_pkg::result_t           result;
    logic                        step;
    logic                        s_fire;

    // configuration is always taken; the user must write only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_addr_reg     <= msrc_pkg::SPEED_ADDR_RESET;
            direction_addr_reg <= msrc_pkg::DIRECTION_ADDR_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                msrc_pkg::CFG_SPEED_ADDR:     speed_addr_reg     <= cfg_data;
                msrc_pkg::CFG_DIRECTION_ADDR: direction_addr_reg <= cfg_data;
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // the registered byte moves on whenever the result register can take
    // whatever it produces
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    msrc_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .rx_byte        (in_byte_reg),
        .frame_start    (in_start_reg),
        .speed_addr     (speed_addr_reg),
        .direction_addr (direction_addr_reg),
        .result         (result)
    );

    // result register: loads on a frame verdict, clears when taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (step && result.valid) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && result.valid) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.reason, out_reg.reading, out_reg.accepted};
    assign m_tuser  = out_reg.kind;

endmodule

>>> hw/rtl/msrc_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msrc_parser
// frame state and per-byte header, data and crc checking
// ----------------------------------------------------------------------------
module msrc_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [msrc_pkg::BYTE_W-1:0]   rx_byte,
    input  logic                          frame_start,
    input  logic [msrc_pkg::BYTE_W-1:0]   speed_addr,
    input  logic [msrc_pkg::BYTE_W-1:0]   direction_addr,
    output msrc_pkg::result_t             result
);

    logic [msrc_pkg::POS_W-1:0]  pos_reg,      pos_next;
    logic                        active_reg,   active_next;
    logic                        dir_reg,      dir_next;
    logic [msrc_pkg::WORD_W-1:0] crc_reg,      crc_next;
    logic [msrc_pkg::WORD_W-1:0] data_reg,     data_next;
    logic [msrc_pkg::BYTE_W-1:0] crc_low_reg,  crc_low_next;

    logic [msrc_pkg::POS_W-1:0]  pos_e;
    logic                        dir_e;
    logic [msrc_pkg::WORD_W-1:0] crc_e;
    logic [msrc_pkg::WORD_W-1:0] data_e;
    logic [msrc_pkg::BYTE_W-1:0] crc_low_e;
    logic [msrc_pkg::POS_W-1:0]  count;
    logic [msrc_pkg::POS_W-1:0]  crc_pos;
    logic                        emit;

    always_comb begin
        // a start mark restarts the frame at this byte
        pos_e     = frame_start ? '0 : pos_reg;
        dir_e     = frame_start ? 1'b0 : dir_reg;
        crc_e     = frame_start ? msrc_pkg::CRC_INIT : crc_reg;
        data_e    = frame_start ? '0 : data_reg;
        crc_low_e = frame_start ? '0 : crc_low_reg;

        count   = dir_e ? msrc_pkg::COUNT_DIRECTION : msrc_pkg::COUNT_SPEED;
        crc_pos = msrc_pkg::POS_DATA_HI + count;

        active_next  = frame_start | active_reg;
        pos_next     = pos_e;
        dir_next     = dir_e;
        crc_next     = crc_e;
        data_next    = data_e;
        crc_low_next = crc_low_e;
        emit         = 1'b0;

        result          = '0;
        result.kind     = dir_e;
        result.reason   = msrc_pkg::FAIL_NONE;

        if (active_next) begin
            if (pos_e == msrc_pkg::POS_ADDRESS) begin
                if (rx_byte == speed_addr) begin
                    dir_next = 1'b0;
                end else if (rx_byte == direction_addr) begin
                    dir_next = 1'b1;
                end else begin
                    emit          = 1'b1;
                    result.kind   = 1'b0;
                    result.reason = msrc_pkg::FAIL_ADDRESS;
                end
            end else if (pos_e == msrc_pkg::POS_FUNCTION) begin
                if (rx_byte != msrc_pkg::FUNC_READ) begin
                    emit          = 1'b1;
                    result.reason = msrc_pkg::FAIL_FUNCTION;
                end
            end else if (pos_e == msrc_pkg::POS_COUNT) begin
                if (rx_byte != {{(msrc_pkg::BYTE_W-msrc_pkg::POS_W){1'b0}}, count}) begin
                    emit          = 1'b1;
                    result.reason = msrc_pkg::FAIL_COUNT;
                end
            end else if (pos_e < crc_pos) begin
                if (pos_e == msrc_pkg::POS_DATA_HI) begin
                    data_next = {rx_byte, data_e[msrc_pkg::BYTE_W-1:0]};
                end else if (pos_e == msrc_pkg::POS_DATA_LO) begin
                    data_next = {data_e[msrc_pkg::WORD_W-1:msrc_pkg::BYTE_W], rx_byte};
                end
            end else if (pos_e == crc_pos) begin
                crc_low_next = rx_byte;
            end else begin
                // both crc bytes must match
                emit = 1'b1;
                if (crc_low_e == crc_e[msrc_pkg::BYTE_W-1:0] &&
                    rx_byte == crc_e[msrc_pkg::WORD_W-1:msrc_pkg::BYTE_W]) begin
                    result.accepted = 1'b1;
                    result.reading  = data_e;
                    result.reason   = msrc_pkg::FAIL_NONE;
                end else begin
                    result.reason   = msrc_pkg::FAIL_CRC;
                end
            end

            if (emit) begin
                active_next = 1'b0;
            end else begin
                if (pos_e < crc_pos) begin
                    crc_next = msrc_pkg::crc_feed(crc_e, rx_byte);
                end
                pos_next = pos_e + 1'b1;
            end
        end

        result.valid = emit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            active_reg  <= 1'b0;
            dir_reg     <= 1'b0;
            crc_reg     <= msrc_pkg::CRC_INIT;
            data_reg    <= '0;
            crc_low_reg <= '0;
        end else if (step) begin
            pos_reg     <= pos_next;
            active_reg  <= active_next;
            dir_reg     <= dir_next;
            crc_reg     <= crc_next;
            data_reg    <= data_next;
            crc_low_reg <= crc_low_next;
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the modbus sensor reply checker: feeds reply bytes
// (good frames, header faults, crc faults, cut frames, stray bytes) through a
// bursty sender and a stalling receiver, predicts at most one verdict per frame with
// its own parser and crc, and compares every result item field by field
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 8;     // result path is two registers deep
    localparam int PHASE_BYTES  = 200;
    localparam int PHASES       = 8;
    localparam logic [msrc_pkg::CFG_IDX_W-1:0] CFG_INDEX_UNUSED = 8'hFF;

    // byte counts as they travel in a reply
    localparam logic [7:0] CNT_SPEED     = {4'h0, msrc_pkg::COUNT_SPEED};
    localparam logic [7:0] CNT_DIRECTION = {4'h0, msrc_pkg::COUNT_DIRECTION};

    typedef logic [7:0] byte_q_t [$];

    typedef struct {
        logic            accepted;
        logic            kind;
        logic [15:0]     reading;
        msrc_pkg::fail_t reason;
    } reply_verdict_t;

    // dut ports
    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [7:0]                     s_tdata;   // [7:0] rx_byte
    logic                           s_tuser;   // [0] frame_start
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [23:0]                    m_tdata;   // [0] accepted, [16:1] reading,
                                               // [19:17] fail_reason
    logic                           m_tuser;   // [0] sensor_kind
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [msrc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [msrc_pkg::BYTE_W-1:0]    cfg_data;

    // predicted register contents and parser state
    logic [7:0]  spd_addr;
    logic [7:0]  dir_addr;
    logic [3:0]  pr_pos;
    logic        pr_active;
    logic        pr_dir;
    logic [15:0] pr_crc;
    logic [15:0] pr_word;
    logic [7:0]  pr_crc_lo;

    reply_verdict_t verdict_q [$];

    int mismatch_cnt = 0;
    int cycle_cnt    = 0;
    int bytes_sent   = 0;
    int burst_left   = 0;
    int stretch_left = 0;
    int stall_pct    = 0;

    // checker scratch
    reply_verdict_t exp_v;
    logic [23:0]    exp_data;

    modbus_sensor_reply_checker_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run guard
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: stretches of free flow alternate with stretches of random stalls
    always @(negedge aclk) begin
        if (stretch_left == 0) begin
            stretch_left = $urandom_range(50, 400);
            stall_pct    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 70);
        end
        stretch_left = stretch_left - 1;
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // crc-16/modbus, one byte, lsb first
    function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] crc,
                                                      input logic [7:0] b);
        logic [15:0] c;
        logic        lsb;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            lsb = c[0];
            c   = {1'b0, c[15:1]};
            if (lsb) begin
                c = c ^ msrc_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    // queue one predicted verdict; a verdict always ends the frame
    task automatic post_verdict(input logic acc, input logic kind,
                                input logic [15:0] rd, input msrc_pkg::fail_t why);
        reply_verdict_t v;
        v.accepted = acc;
        v.kind     = kind;
        v.reading  = rd;
        v.reason   = why;
        verdict_q.push_back(v);
        pr_active = 1'b0;
    endtask

    // parser prediction for one accepted reply byte
    task automatic predict_reply_byte(input logic [7:0] b, input logic start);
        logic [3:0] need;
        logic       kind;
        if (start) begin
            pr_active = 1'b1;
            pr_pos    = msrc_pkg::POS_ADDRESS;
            pr_dir    = 1'b0;
            pr_crc    = msrc_pkg::CRC_INIT;
            pr_word   = 16'h0000;
            pr_crc_lo = 8'h00;
        end
        if (!pr_active) begin
            return;   // stray byte outside a frame
        end
        kind = pr_dir;
        need = pr_dir ? msrc_pkg::COUNT_DIRECTION : msrc_pkg::COUNT_SPEED;
        if (pr_pos == msrc_pkg::POS_ADDRESS) begin
            // speed address wins when both registers hold the same value
            if (b == spd_addr) begin
                pr_dir = 1'b0;
            end else if (b == dir_addr) begin
                pr_dir = 1'b1;
            end else begin
                post_verdict(1'b0, 1'b0, 16'h0000, msrc_pkg::FAIL_ADDRESS);
                return;
            end
        end else if (pr_pos == msrc_pkg::POS_FUNCTION) begin
            if (b != msrc_pkg::FUNC_READ) begin
                post_verdict(1'b0, kind, 16'h0000, msrc_pkg::FAIL_FUNCTION);
                return;
            end
        end else if (pr_pos == msrc_pkg::POS_COUNT) begin
            if (b != {4'h0, need}) begin
                post_verdict(1'b0, kind, 16'h0000, msrc_pkg::FAIL_COUNT);
                return;
            end
        end else if (pr_pos < msrc_pkg::POS_DATA_HI + need) begin
            if (pr_pos == msrc_pkg::POS_DATA_HI) begin
                pr_word[15:8] = b;
            end else if (pr_pos == msrc_pkg::POS_DATA_LO) begin
                pr_word[7:0] = b;
            end
        end else if (pr_pos == msrc_pkg::POS_DATA_HI + need) begin
            pr_crc_lo = b;
        end else begin
            // both crc bytes have to match
            if (pr_crc_lo == pr_crc[7:0] && b == pr_crc[15:8]) begin
                post_verdict(1'b1, kind, pr_word, msrc_pkg::FAIL_NONE);
            end else begin
                post_verdict(1'b0, kind, 16'h0000, msrc_pkg::FAIL_CRC);
            end
            return;
        end
        if (pr_pos < msrc_pkg::POS_DATA_HI + need) begin
            pr_crc = crc16_modbus_byte(pr_crc, b);
        end
        pr_pos = pr_pos + 4'd1;
    endtask

    // send one reply byte; bursts of random length with random gaps between
    task automatic send_rx_byte(input logic [7:0] b, input logic start);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        predict_reply_byte(b, start);
        bytes_sent = bytes_sent + 1;
        if (burst_left > 0) begin
            burst_left = burst_left - 1;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 6);
                repeat (gap) begin
                    @(negedge aclk);
                    s_tvalid <= 1'b0;
                end
            end
        end
    endtask

    // first len bytes of a frame, start mark on the first
    task automatic send_frame(input byte_q_t q, input int len);
        for (int i = 0; i < len; i++) begin
            send_rx_byte(q[i], i == 0);
        end
    endtask

    // header, data word, ndata-2 extra data bytes, then crc low and high
    task automatic build_reply(input logic [7:0] addr, input logic [7:0] func,
                               input logic [7:0] cnt, input logic [7:0] ndata,
                               input logic [15:0] word, output byte_q_t q);
        logic [15:0] crc;
        q = {};
        q.push_back(addr);
        q.push_back(func);
        q.push_back(cnt);
        q.push_back(word[15:8]);
        q.push_back(word[7:0]);
        for (int i = 2; i < int'(ndata); i++) begin
            q.push_back(8'($urandom_range(0, 255)));
        end
        crc = msrc_pkg::CRC_INIT;
        foreach (q[i]) begin
            crc = crc16_modbus_byte(crc, q[i]);
        end
        q.push_back(crc[7:0]);
        q.push_back(crc[15:8]);
    endtask

    task automatic send_reply(input logic [7:0] addr, input logic [7:0] func,
                              input logic [7:0] cnt, input logic [7:0] ndata,
                              input logic [15:0] word);
        byte_q_t q;
        build_reply(addr, func, cnt, ndata, word, q);
        send_frame(q, q.size());
    endtask

    // stop sending and let every pending result come out
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [msrc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == msrc_pkg::CFG_SPEED_ADDR) begin
            spd_addr = val;
        end else if (idx == msrc_pkg::CFG_DIRECTION_ADDR) begin
            dir_addr = val;
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_addresses(input logic [7:0] sa, input logic [7:0] da);
        wait_drained();
        write_cfg(msrc_pkg::CFG_SPEED_ADDR, sa);
        write_cfg(msrc_pkg::CFG_DIRECTION_ADDR, da);
    endtask

    function automatic logic [15:0] random_reading();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 16'h0000;
        end else if (r == 1) begin
            return 16'hFFFF;
        end
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    // ------------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------------

    // reset addresses, both kinds, reading extremes
    task automatic test_good_replies();
        send_reply(msrc_pkg::SPEED_ADDR_RESET, msrc_pkg::FUNC_READ, CNT_SPEED, CNT_SPEED,
                   16'h0000);
        send_reply(msrc_pkg::SPEED_ADDR_RESET, msrc_pkg::FUNC_READ, CNT_SPEED, CNT_SPEED,
                   16'hFFFF);
        send_reply(msrc_pkg::DIRECTION_ADDR_RESET, msrc_pkg::FUNC_READ, CNT_DIRECTION,
                   CNT_DIRECTION, 16'h0000);
        send_reply(msrc_pkg::DIRECTION_ADDR_RESET, msrc_pkg::FUNC_READ, CNT_DIRECTION,
                   CNT_DIRECTION, 16'hFFFF);
        wait_drained();
    endtask

    // each header check, and each crc byte alone
    task automatic test_header_faults();
        byte_q_t q;
        send_reply(8'h00, msrc_pkg::FUNC_READ, CNT_SPEED, CNT_SPEED, 16'h1234);
        send_reply(8'hFF, msrc_pkg::FUNC_READ, CNT_SPEED, CNT_SPEED, 16'h1234);
        send_reply(msrc_pkg::SPEED_ADDR_RESET, 8'h04, CNT_SPEED, CNT_SPEED, 16'h00A5);
        // count of the other kind, both ways
        send_reply(msrc_pkg::SPEED_ADDR_RESET, msrc_pkg::FUNC_READ, CNT_DIRECTION,
                   CNT_DIRECTION, 16'h5A5A);
        send_reply(msrc_pkg::DIRECTION_ADDR_RESET, msrc_pkg::FUNC_READ, CNT_SPEED,
                   CNT_SPEED, 16'h0168);
        // bad low crc byte with a good high byte, then the reverse
        build_reply(msrc_pkg::SPEED_ADDR_RESET, msrc_pkg::FUNC_READ, CNT_SPEED, CNT_SPEED,
                    16'h00C8, q);
        q[q.size()-2] = q[q.size()-2] ^ 8'h01;
        send_frame(q, q.size());
        build_reply(msrc_pkg::DIRECTION_ADDR_RESET, msrc_pkg::FUNC_READ, CNT_DIRECTION,
                    CNT_DIRECTION, 16'h010E, q);
        q[q.size()-1] = q[q.size()-1] ^ 8'h80;
        send_frame(q, q.size());
        wait_drained();
    endtask

    // stray bytes while idle, restart mid-frame, bytes after a finished frame
    task automatic test_framing();
        byte_q_t q;
        send_rx_byte(msrc_pkg::SPEED_ADDR_RESET, 1'b0);
        send_rx_byte(msrc_pkg::FUNC_READ, 1'b0);
        build_reply(msrc_pkg::DIRECTION_ADDR_RESET, msrc_pkg::FUNC_READ, CNT_DIRECTION,
                    CNT_DIRECTION, 16'h0077, q);
        send_frame(q, 5);
        send_reply(msrc_pkg::SPEED_ADDR_RESET, msrc_pkg::FUNC_READ, CNT_SPEED, CNT_SPEED,
                   16'h0032);
        send_rx_byte(8'hA5, 1'b0);
        send_rx_byte(8'h5A, 1'b0);
        wait_drained();
    endtask

    // address registers at their extremes, equal, and an unused index
    task automatic test_address_config();
        set_addresses(8'd247, 8'd1);
        send_reply(8'd247, msrc_pkg::FUNC_READ, CNT_SPEED, CNT_SPEED, 16'h0102);
        send_reply(8'd1, msrc_pkg::FUNC_READ, CNT_DIRECTION, CNT_DIRECTION, 16'h0103);
        send_reply(msrc_pkg::DIRECTION_ADDR_RESET, msrc_pkg::FUNC_READ, CNT_DIRECTION,
                   CNT_DIRECTION, 16'h0104);
        // equal addresses: the frame counts as speed
        set_addresses(8'h55, 8'h55);
        send_reply(8'h55, msrc_pkg::FUNC_READ, CNT_SPEED, CNT_SPEED, 16'h0105);
        send_reply(8'h55, msrc_pkg::FUNC_READ, CNT_DIRECTION, CNT_DIRECTION, 16'h0106);
        // write to an unused index must leave both addresses alone
        wait_drained();
        write_cfg(CFG_INDEX_UNUSED, 8'hAA);
        send_reply(8'h55, msrc_pkg::FUNC_READ, CNT_SPEED, CNT_SPEED, 16'h0107);
        wait_drained();
    endtask

    // one random frame, mostly well formed
    task automatic random_reply();
        byte_q_t    q;
        logic       want_dir;
        logic       dir_frame;
        logic [7:0] addr;
        logic [7:0] need;
        logic [7:0] mask;
        int         pick;
        want_dir  = 1'($urandom_range(0, 1));
        dir_frame = want_dir && (dir_addr != spd_addr);
        addr      = want_dir ? dir_addr : spd_addr;
        need      = dir_frame ? CNT_DIRECTION : CNT_SPEED;
        build_reply(addr, msrc_pkg::FUNC_READ, need, need, random_reading(), q);
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            send_frame(q, q.size());
        end else if (pick < 65) begin
            do q[0] = 8'($urandom_range(0, 255));
            while (q[0] == spd_addr || q[0] == dir_addr);
            send_frame(q, q.size());
        end else if (pick < 70) begin
            do q[1] = 8'($urandom_range(0, 255)); while (q[1] == msrc_pkg::FUNC_READ);
            send_frame(q, q.size());
        end else if (pick < 75) begin
            do q[2] = 8'($urandom_range(0, 255)); while (q[2] == need);
            send_frame(q, q.size());
        end else if (pick < 82) begin
            mask = 8'($urandom_range(1, 255));
            case ($urandom_range(0, 2))
                0: begin
                    q[q.size()-2] = q[q.size()-2] ^ mask;
                end
                1: begin
                    q[q.size()-1] = q[q.size()-1] ^ mask;
                end
                default: begin
                    q[q.size()-2] = q[q.size()-2] ^ mask;
                    q[q.size()-1] = q[q.size()-1] ^ 8'($urandom_range(1, 255));
                end
            endcase
            send_frame(q, q.size());
        end else if (pick < 88) begin
            // cut short; the next start mark drops it
            send_frame(q, $urandom_range(1, q.size() - 1));
        end else if (pick < 94) begin
            send_frame(q, q.size());
            repeat ($urandom_range(1, 3)) send_rx_byte(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            repeat ($urandom_range(1, 4)) begin
                send_rx_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
        end
    endtask

    // random traffic over several address settings
    task automatic test_random_traffic();
        logic [7:0] sa;
        logic [7:0] da;
        int         target;
        for (int ph = 0; ph < PHASES; ph++) begin
            sa = 8'($urandom_range(1, 247));
            da = 8'($urandom_range(1, 247));
            case (ph)
                0: begin
                    sa = 8'd1;
                    da = 8'd247;
                end
                1: begin
                    sa = 8'd247;
                    da = 8'd1;
                end
                2: begin
                    da = sa;
                end
                default: begin
                    while (da == sa) da = 8'($urandom_range(1, 247));
                end
            endcase
            set_addresses(sa, da);
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) random_reply();
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // result checking: every result item against the oldest verdict
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                mismatch_cnt = mismatch_cnt + 1;
                if (mismatch_cnt <= 10) begin
                    $display("unexpected result item: tdata=%06h tuser=%0b",
                             m_tdata, m_tuser);
                end
            end else begin
                exp_v    = verdict_q.pop_front();
                exp_data = {4'h0, exp_v.reason, exp_v.reading, exp_v.accepted};
                if (m_tdata !== exp_data || m_tuser !== exp_v.kind) begin
                    mismatch_cnt = mismatch_cnt + 1;
                    if (mismatch_cnt <= 10) begin
                        $display("result mismatch at cycle %0d", cycle_cnt);
                        $display("  expected accepted=%0b kind=%0b reading=%04h reason=%0d",
                                 exp_v.accepted, exp_v.kind, exp_v.reading, exp_v.reason);
                        $display("  actual   accepted=%0b kind=%0b reading=%04h reason=%0d pad=%h",
                                 m_tdata[0], m_tuser, m_tdata[16:1], m_tdata[19:17],
                                 m_tdata[23:20]);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = msrc_pkg::CFG_SPEED_ADDR;
        cfg_data  = 8'h00;
        spd_addr  = msrc_pkg::SPEED_ADDR_RESET;
        dir_addr  = msrc_pkg::DIRECTION_ADDR_RESET;
        pr_pos    = msrc_pkg::POS_ADDRESS;
        pr_active = 1'b0;
        pr_dir    = 1'b0;
        pr_crc    = msrc_pkg::CRC_INIT;
        pr_word   = 16'h0000;
        pr_crc_lo = 8'h00;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_good_replies();
        test_header_faults();
        test_framing();
        test_address_config();
        test_random_traffic();

        if (mismatch_cnt == 0 && verdict_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
